FILE: rtl/glzw_pkg.sv
// Shared types, constants and helpers for the GIF LZW pixel decoder.
// Used by glzw_front, glzw_back and gif_lzw_pixel_decoder; depends on nothing.
package glzw_pkg;

    localparam int TABLE_ENTRIES_DEF     = 4096;
    localparam int STACK_DEPTH_DEF       = 4096;
    localparam int BYTE_BUFFER_DEPTH_DEF = 256;
    localparam int MAX_CODE_BITS_DEF     = 12;

    localparam int CODE_W = 13;
    localparam int ACC_W  = 20;
    localparam int BC_W   = 5;
    localparam int ROOT_W = 4;

    localparam logic [CODE_W-1:0] NONE_CODE = 13'h1FFF;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_MORE  = 3'd1;
    localparam logic [2:0] ST_EOI   = 3'd2;
    localparam logic [2:0] ST_END   = 3'd3;
    localparam logic [2:0] ST_DROP  = 3'd4;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_BYTE  = 2'd1,
        CMD_PIXEL = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data;
    } item_t;

    // Clamps the minimum code size register to the legal range of 1 to 8.
    function automatic logic [ROOT_W-1:0] root_eff(input logic [ROOT_W-1:0] r);
        logic [ROOT_W-1:0] v;
        v = r;
        if (v < 4'd1) v = 4'd1;
        if (v > 4'd8) v = 4'd8;
        return v;
    endfunction

endpackage

FILE: rtl/glzw_front.sv
// Command front end: accepts items and queues them for the decode engine.
// Depends on glzw_pkg for the item type.
module glzw_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_cmd,
    input  logic [7:0]         in_data,
    output logic               q_valid,
    output glzw_pkg::item_t    q_item,
    input  logic               q_pop
);

    glzw_pkg::item_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push, pop;
    glzw_pkg::item_t in_item;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        in_item.cmd  = glzw_pkg::cmd_t'(in_cmd);
        in_item.data = in_data;
        wr_ptr_next  = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next  = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next     = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/glzw_back.sv
// Decode engine: byte buffer, code unpacking, string tables and pixel stack.
// Depends on glzw_pkg; fed by glzw_front and drives the result register.
module glzw_back #(
    parameter int TABLE_ENTRIES     = glzw_pkg::TABLE_ENTRIES_DEF,
    parameter int STACK_DEPTH       = glzw_pkg::STACK_DEPTH_DEF,
    parameter int BYTE_BUFFER_DEPTH = glzw_pkg::BYTE_BUFFER_DEPTH_DEF,
    parameter int MAX_CODE_BITS     = glzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [glzw_pkg::ROOT_W-1:0] root_bits,
    input  logic                        q_valid,
    input  glzw_pkg::item_t             q_item,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  out_pixel,
    output logic [2:0]                  out_status
);

    localparam int TAB_AW = $clog2(TABLE_ENTRIES);
    localparam int LNK_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int STK_AW = $clog2(STACK_DEPTH);
    localparam int SP_W   = $clog2(STACK_DEPTH + 1);
    localparam int BUF_AW = $clog2(BYTE_BUFFER_DEPTH);
    localparam int CNT_W  = $clog2(BYTE_BUFFER_DEPTH + 1);
    localparam int SUM_W  = CNT_W + 1;
    localparam int CW     = glzw_pkg::CODE_W;
    localparam int AW     = glzw_pkg::ACC_W;
    localparam int BW     = glzw_pkg::BC_W;
    localparam int RW     = glzw_pkg::ROOT_W;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_FILL_CHK, S_FILL_USE, S_WALK, S_FIX, S_ADD,
        S_POP_RD, S_POP_OUT, S_RESP
    } state_t;

    logic [CW-1:0] prefix_mem [TABLE_ENTRIES];
    logic [7:0]    suffix_mem [TABLE_ENTRIES];
    logic [7:0]    stack_mem  [STACK_DEPTH];
    logic [7:0]    buf_mem    [BYTE_BUFFER_DEPTH];

    logic [CW-1:0]     pre_q;
    logic [7:0]        suf_q, stk_q, buf_q;
    logic              tab_we;
    logic [TAB_AW-1:0] tab_waddr, tab_raddr;
    logic [CW-1:0]     tab_wpre;
    logic [7:0]        tab_wsuf;
    logic              stk_we;
    logic [STK_AW-1:0] stk_waddr, stk_raddr;
    logic [7:0]        stk_wdata;
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr, buf_raddr;

    state_t            state_reg, state_next;
    logic [TAB_AW-1:0] sweep_reg, sweep_next;
    logic              sresp_reg, sresp_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [BUF_AW-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]        sub_reg, sub_next;
    logic [AW-1:0]     acc_reg, acc_next;
    logic [BW-1:0]     bc_reg, bc_next;
    logic [RW-1:0]     cur_reg, cur_next;
    logic [CW-1:0]     nfc_reg, nfc_next;
    logic [CW-1:0]     prev_reg, prev_next;
    logic              ended_reg, ended_next;
    logic [CW-1:0]     c_reg, c_next;
    logic [CW-1:0]     code_reg, code_next;
    logic [LNK_W-1:0]  links_reg, links_next;
    logic [7:0]        first_reg, first_next;
    logic [SP_W-1:0]   slot_reg, slot_next;
    logic              held_reg, held_next;
    logic              kwk_reg, kwk_next;
    logic              add_reg, add_next;
    logic [7:0]        pix_reg, pix_next;
    logic [2:0]        stat_reg, stat_next;
    logic              ov_reg, ov_next;
    logic [7:0]        opix_reg, opix_next;
    logic [2:0]        ostat_reg, ostat_next;

    logic [RW-1:0]     root;
    logic [8:0]        clr;
    logic [CW-1:0]     clr_c, eoi_c;
    logic [AW-1:0]     mask;
    logic [CW-1:0]     code;
    logic [SUM_W-1:0]  wsum;
    logic [CW-1:0]     wp;
    logic [7:0]        ws;
    logic              out_free;

    assign out_valid  = ov_reg;
    assign out_pixel  = opix_reg;
    assign out_status = ostat_reg;
    assign out_free   = !ov_reg || out_ready;

    always_comb begin
        root  = glzw_pkg::root_eff(root_bits);
        clr   = 9'(9'd1 << root);
        clr_c = CW'(clr);
        eoi_c = CW'(clr_c + CW'(1));
        mask  = AW'((AW'(1) << cur_reg) - AW'(1));
        code  = CW'(acc_reg & mask);
        wsum  = SUM_W'(rd_reg) + SUM_W'(cnt_reg);
        if (wsum >= SUM_W'(BYTE_BUFFER_DEPTH)) begin
            wsum = SUM_W'(wsum - SUM_W'(BYTE_BUFFER_DEPTH));
        end
        if (c_reg >= CW'(TABLE_ENTRIES)) begin
            wp = glzw_pkg::NONE_CODE;
            ws = c_reg[7:0];
        end else begin
            wp = pre_q;
            ws = suf_q;
        end
    end

    always_comb begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        sresp_next = sresp_reg;
        sp_next    = sp_reg;
        rd_next    = rd_reg;
        cnt_next   = cnt_reg;
        sub_next   = sub_reg;
        acc_next   = acc_reg;
        bc_next    = bc_reg;
        cur_next   = cur_reg;
        nfc_next   = nfc_reg;
        prev_next  = prev_reg;
        ended_next = ended_reg;
        c_next     = c_reg;
        code_next  = code_reg;
        links_next = links_reg;
        first_next = first_reg;
        slot_next  = slot_reg;
        held_next  = held_reg;
        kwk_next   = kwk_reg;
        add_next   = add_reg;
        pix_next   = pix_reg;
        stat_next  = stat_reg;
        ov_next    = ov_reg;
        opix_next  = opix_reg;
        ostat_next = ostat_reg;
        q_pop      = 1'b0;
        tab_we     = 1'b0;
        tab_waddr  = sweep_reg;
        tab_wpre   = glzw_pkg::NONE_CODE;
        tab_wsuf   = 8'(sweep_reg);
        tab_raddr  = '0;
        stk_we     = 1'b0;
        stk_waddr  = STK_AW'(sp_reg);
        stk_wdata  = ws;
        stk_raddr  = STK_AW'(sp_reg - SP_W'(1));
        buf_we     = 1'b0;
        buf_waddr  = BUF_AW'(wsum);
        buf_raddr  = rd_reg;

        if (ov_reg && out_ready) begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_SWEEP: begin
                tab_we     = 1'b1;
                sweep_next = TAB_AW'(sweep_reg + TAB_AW'(1));
                if (sweep_reg == TAB_AW'(TABLE_ENTRIES - 1)) begin
                    sweep_next = '0;
                    state_next = sresp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    pix_next  = 8'd0;
                    stat_next = glzw_pkg::ST_OK;
                    case (q_item.cmd)
                        glzw_pkg::CMD_START: begin
                            sp_next    = '0;
                            rd_next    = '0;
                            cnt_next   = '0;
                            sub_next   = 8'd0;
                            acc_next   = '0;
                            bc_next    = '0;
                            ended_next = 1'b0;
                            cur_next   = RW'(root + RW'(1));
                            nfc_next   = CW'(clr_c + CW'(2));
                            prev_next  = glzw_pkg::NONE_CODE;
                            sresp_next = 1'b1;
                            sweep_next = '0;
                            state_next = S_SWEEP;
                        end
                        glzw_pkg::CMD_BYTE: begin
                            state_next = S_RESP;
                            if (ended_reg) begin
                                stat_next = glzw_pkg::ST_END;
                            end else if (sub_reg == 8'd0) begin
                                if (q_item.data == 8'd0) begin
                                    ended_next = 1'b1;
                                    stat_next  = glzw_pkg::ST_END;
                                end else begin
                                    sub_next = q_item.data;
                                end
                            end else begin
                                sub_next = 8'(sub_reg - 8'd1);
                                if (cnt_reg >= CNT_W'(BYTE_BUFFER_DEPTH)) begin
                                    stat_next = glzw_pkg::ST_DROP;
                                end else begin
                                    buf_we   = 1'b1;
                                    cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
                                end
                            end
                        end
                        glzw_pkg::CMD_PIXEL: begin
                            state_next = (sp_reg != '0) ? S_POP_RD : S_FILL_CHK;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_FILL_CHK: begin
                if (bc_reg < BW'(cur_reg)) begin
                    if (cnt_reg == '0) begin
                        stat_next  = ended_reg ? glzw_pkg::ST_END : glzw_pkg::ST_MORE;
                        state_next = S_RESP;
                    end else begin
                        rd_next    = (rd_reg == BUF_AW'(BYTE_BUFFER_DEPTH - 1)) ?
                                     '0 : BUF_AW'(rd_reg + BUF_AW'(1));
                        cnt_next   = CNT_W'(cnt_reg - CNT_W'(1));
                        state_next = S_FILL_USE;
                    end
                end else begin
                    acc_next   = acc_reg >> cur_reg;
                    bc_next    = BW'(bc_reg - BW'(cur_reg));
                    code_next  = code;
                    links_next = '0;
                    kwk_next   = 1'b0;
                    held_next  = 1'b0;
                    if (code == clr_c) begin
                        cur_next  = RW'(root + RW'(1));
                        nfc_next  = CW'(clr_c + CW'(2));
                        prev_next = glzw_pkg::NONE_CODE;
                    end else if (code == eoi_c) begin
                        stat_next  = glzw_pkg::ST_EOI;
                        state_next = S_RESP;
                    end else if (prev_reg == glzw_pkg::NONE_CODE) begin
                        c_next     = code;
                        tab_raddr  = TAB_AW'(code);
                        prev_next  = code;
                        add_next   = 1'b0;
                        state_next = S_WALK;
                    end else if (code < nfc_reg) begin
                        c_next     = code;
                        tab_raddr  = TAB_AW'(code);
                        add_next   = 1'b1;
                        state_next = S_WALK;
                    end else begin
                        c_next     = prev_reg;
                        tab_raddr  = TAB_AW'(prev_reg);
                        add_next   = 1'b1;
                        kwk_next   = 1'b1;
                        slot_next  = sp_reg;
                        held_next  = (sp_reg < SP_W'(STACK_DEPTH));
                        if (sp_reg < SP_W'(STACK_DEPTH)) begin
                            sp_next = SP_W'(sp_reg + SP_W'(1));
                        end
                        state_next = S_WALK;
                    end
                end
            end
            S_FILL_USE: begin
                acc_next   = acc_reg | (AW'(buf_q) << bc_reg);
                bc_next    = BW'(bc_reg + BW'(8));
                state_next = S_FILL_CHK;
            end
            S_WALK: begin
                if (sp_reg < SP_W'(STACK_DEPTH)) begin
                    stk_we  = 1'b1;
                    sp_next = SP_W'(sp_reg + SP_W'(1));
                end
                if (wp != glzw_pkg::NONE_CODE && links_reg < LNK_W'(TABLE_ENTRIES)) begin
                    c_next     = wp;
                    tab_raddr  = TAB_AW'(wp);
                    links_next = LNK_W'(links_reg + LNK_W'(1));
                end else begin
                    first_next = ws;
                    if (kwk_reg && held_reg) begin
                        state_next = S_FIX;
                    end else if (add_reg) begin
                        state_next = S_ADD;
                    end else begin
                        state_next = S_POP_RD;
                    end
                end
            end
            S_FIX: begin
                stk_we     = 1'b1;
                stk_waddr  = STK_AW'(slot_reg);
                stk_wdata  = first_reg;
                state_next = S_ADD;
            end
            S_ADD: begin
                if (nfc_reg < CW'(TABLE_ENTRIES)) begin
                    tab_we    = 1'b1;
                    tab_waddr = TAB_AW'(nfc_reg);
                    tab_wpre  = prev_reg;
                    tab_wsuf  = first_reg;
                    if (nfc_reg == CW'((CW'(1) << cur_reg) - CW'(1)) &&
                        cur_reg < RW'(MAX_CODE_BITS)) begin
                        cur_next = RW'(cur_reg + RW'(1));
                    end
                    nfc_next = CW'(nfc_reg + CW'(1));
                end
                prev_next  = code_reg;
                state_next = S_POP_RD;
            end
            S_POP_RD: begin
                sp_next    = SP_W'(sp_reg - SP_W'(1));
                state_next = S_POP_OUT;
            end
            S_POP_OUT: begin
                pix_next   = stk_q;
                stat_next  = glzw_pkg::ST_OK;
                state_next = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    opix_next  = (stat_reg == glzw_pkg::ST_OK) ? pix_reg : 8'd0;
                    ostat_next = stat_reg;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_SWEEP;
            sweep_reg <= '0;
            sresp_reg <= 1'b0;
            sp_reg    <= '0;
            rd_reg    <= '0;
            cnt_reg   <= '0;
            sub_reg   <= 8'd0;
            acc_reg   <= '0;
            bc_reg    <= '0;
            cur_reg   <= RW'(4'd9);
            nfc_reg   <= CW'(258);
            prev_reg  <= glzw_pkg::NONE_CODE;
            ended_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            sresp_reg <= sresp_next;
            sp_reg    <= sp_next;
            rd_reg    <= rd_next;
            cnt_reg   <= cnt_next;
            sub_reg   <= sub_next;
            acc_reg   <= acc_next;
            bc_reg    <= bc_next;
            cur_reg   <= cur_next;
            nfc_reg   <= nfc_next;
            prev_reg  <= prev_next;
            ended_reg <= ended_next;
            ov_reg    <= ov_next;
        end
        c_reg     <= c_next;
        code_reg  <= code_next;
        links_reg <= links_next;
        first_reg <= first_next;
        slot_reg  <= slot_next;
        held_reg  <= held_next;
        kwk_reg   <= kwk_next;
        add_reg   <= add_next;
        pix_reg   <= pix_next;
        stat_reg  <= stat_next;
        opix_reg  <= opix_next;
        ostat_reg <= ostat_next;
    end

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            prefix_mem[tab_waddr] <= tab_wpre;
            suffix_mem[tab_waddr] <= tab_wsuf;
        end
        pre_q <= prefix_mem[tab_raddr];
        suf_q <= suffix_mem[tab_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stack_mem[stk_waddr] <= stk_wdata;
        end
        stk_q <= stack_mem[stk_raddr];
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= q_item.data;
        end
        buf_q <= buf_mem[buf_raddr];
    end

endmodule

FILE: rtl/gif_lzw_pixel_decoder.sv
// Top level of the GIF LZW pixel decoder: configuration register and wiring.
// Depends on glzw_pkg, glzw_front and glzw_back.
//
// Usage: each item on the s_ channel carries a command in s_tuser (start image,
// stream byte, or pixel request) and a raw stream byte in s_tdata. Every item
// gives exactly one result item on the m_ channel: a palette index in m_tdata
// and a status code in m_tuser. The minimum code size is written through
// cfg_we/cfg_wdata; the user is to write it only while the block is idle, as
// the block itself does not enforce this. A stream byte goes straight from idle
// to the result state; a pixel already on the stack is read from the stack and
// then made the result. The engine takes no new item until the last result has
// been passed to the result register. When the stack is empty, each code first
// unpacks buffer bytes, then is decoded; the prefix walk reads one table entry
// per cycle and pushes one pixel of its string each, the stack may be patched
// and a table entry added, and the first pixel pops. After reset and each
// start command, a clearing pass rewrites the tables ahead of the next item.
// A two-item input queue and a result register separate the channels; when the
// receiver stalls, the result holds and the queue keeps taking items until full.
module gif_lzw_pixel_decoder #(
    parameter int TABLE_ENTRIES     = glzw_pkg::TABLE_ENTRIES_DEF,
    parameter int STACK_DEPTH       = glzw_pkg::STACK_DEPTH_DEF,
    parameter int BYTE_BUFFER_DEPTH = glzw_pkg::BYTE_BUFFER_DEPTH_DEF,
    parameter int MAX_CODE_BITS     = glzw_pkg::MAX_CODE_BITS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [3:0] cfg_wdata,       // root_code_bits
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,         // stream_byte
    input  logic [1:0] s_tuser,         // command
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,         // pixel_index
    output logic [2:0] m_tuser          // status
);

    logic [glzw_pkg::ROOT_W-1:0] root_reg, root_next;
    logic                        q_valid;
    logic                        q_pop;
    glzw_pkg::item_t             q_item;

    always_comb begin
        root_next = cfg_we ? cfg_wdata : root_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= 4'd8;
        end else begin
            root_reg <= root_next;
        end
    end

    glzw_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser),
        .in_data  (s_tdata),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    glzw_back #(
        .TABLE_ENTRIES     (TABLE_ENTRIES),
        .STACK_DEPTH       (STACK_DEPTH),
        .BYTE_BUFFER_DEPTH (BYTE_BUFFER_DEPTH),
        .MAX_CODE_BITS     (MAX_CODE_BITS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .root_bits  (root_reg),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_pixel  (m_tdata),
        .out_status (m_tuser)
    );

endmodule
